### src/ordered_list_with_search_assert.svh
// ----------------------------------------------------------------------------
// ordered_list_with_search assertion macros
// Short forms for clocked properties used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_WITH_SEARCH_ASSERT_SVH
`define ORDERED_LIST_WITH_SEARCH_ASSERT_SVH

// antecedent in this cycle implies consequent in the next cycle
`define OLWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define OLWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after reset is seen
`define OLWS_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

### src/olws_pkg.sv
// ----------------------------------------------------------------------------
// olws_pkg
// Shared widths, request and status codes for the ordered list block.
// ----------------------------------------------------------------------------
package olws_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OP_W      = 3;
  localparam int DATA_W    = 32;
  localparam int ST_W      = 2;

  // request codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP       = 3'd5;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic                     vld;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } olws_emit_t;

endpackage

### src/olws_if.sv
// ----------------------------------------------------------------------------
// olws request / response channels
// Valid-ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface olws_in_if;
  logic                              valid;
  logic                              ready;
  logic [olws_pkg::OP_W-1:0]         op;
  logic signed [olws_pkg::DATA_W-1:0] item;

  modport source (output valid, output op, output item, input ready);
  modport sink   (input valid, input op, input item, output ready);
endinterface

interface olws_out_if #(
  parameter int POS_W = $clog2(olws_pkg::DEPTH_DEF + 1)
);
  logic                              valid;
  logic                              ready;
  logic [olws_pkg::ST_W-1:0]         status;
  logic signed [olws_pkg::DATA_W-1:0] value;
  logic [POS_W-1:0]                  position;
  logic                              last;

  modport source (output valid, output status, output value, output position,
                  output last, input ready);
  modport sink   (input valid, input status, input value, input position,
                  input last, output ready);
endinterface

### src/olws_ram.sv
// ----------------------------------------------------------------------------
// olws_ram
// Ring element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module olws_ram #(
  parameter int DEPTH = olws_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(DEPTH)-1:0]           waddr,
  input  logic signed [olws_pkg::DATA_W-1:0] wdata,
  input  logic                               re,
  input  logic [$clog2(DEPTH)-1:0]           raddr,
  output logic signed [olws_pkg::DATA_W-1:0] rdata
);

  logic signed [olws_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/olws_ctrl.sv
// ----------------------------------------------------------------------------
// olws_ctrl
// Sequencer: ring pointers, store access and the shared compare unit.
// ----------------------------------------------------------------------------
module olws_ctrl #(
  parameter int DEPTH = olws_pkg::DEPTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      req_valid,
  output logic                                      req_ready,
  input  logic [olws_pkg::OP_W-1:0]                 req_op,
  input  logic signed [olws_pkg::DATA_W-1:0]        req_item,
  input  logic                                      out_free,
  output olws_pkg::olws_emit_t                      emit,
  output logic [$clog2(DEPTH+1)-1:0]                emit_pos,
  output logic                                      mem_we,
  output logic [$clog2(DEPTH)-1:0]                  mem_waddr,
  output logic signed [olws_pkg::DATA_W-1:0]        mem_wdata,
  output logic                                      mem_re,
  output logic [$clog2(DEPTH)-1:0]                  mem_raddr,
  input  logic signed [olws_pkg::DATA_W-1:0]        mem_rdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DUMP   = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]                        state;
  logic [IW-1:0]                     front;
  logic [CW-1:0]                     count;
  logic [IW-1:0]                     idx;
  logic [IW-1:0]                     ptr;
  logic signed [olws_pkg::DATA_W-1:0] item_q;
  logic [olws_pkg::ST_W-1:0]         res_status;
  logic signed [olws_pkg::DATA_W-1:0] res_value;
  logic [CW-1:0]                     res_pos;

  logic          accept, full, empty, hit, last_el;
  logic [IW-1:0] front_dec, front_inc, ptr_inc, back_wr, back_rd;
  logic [CW-1:0] cnt_m1, idx_p1;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
    logic [SW-1:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign cnt_m1    = count - CW'(1);
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
  assign ptr_inc   = (ptr == IW'(DEPTH - 1)) ? '0 : ptr + IW'(1);
  assign back_wr   = wrap_add(front, count[IW-1:0]);
  assign back_rd   = wrap_add(front, cnt_m1[IW-1:0]);
  assign idx_p1    = CW'(idx) + CW'(1);
  assign last_el   = (idx_p1 == count);

  // shared compare unit: one stored element against the search key per cycle
  assign hit = (mem_rdata == item_q);

  // store write: inserts only, straight from the request
  always_comb begin
    mem_we    = accept && !full &&
                (req_op == olws_pkg::OP_PUSH_FRONT || req_op == olws_pkg::OP_PUSH_BACK);
    mem_waddr = (req_op == olws_pkg::OP_PUSH_FRONT) ? front_dec : back_wr;
    mem_wdata = req_item;
  end

  // store read
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = front;
    case (state)
      S_IDLE: begin
        if (accept && !empty) begin
          case (req_op)
            olws_pkg::OP_POP_FRONT, olws_pkg::OP_SEARCH, olws_pkg::OP_DUMP: begin
              mem_re = 1'b1;
            end
            olws_pkg::OP_POP_BACK: begin
              mem_re    = 1'b1;
              mem_raddr = back_rd;
            end
            default: begin
              mem_re = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        mem_re    = !hit && !last_el;
        mem_raddr = ptr_inc;
      end
      S_DUMP: begin
        mem_re    = out_free && !last_el;
        mem_raddr = ptr_inc;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // result toward the output register, gated by its free slot
  always_comb begin
    emit.vld    = 1'b0;
    emit.status = res_status;
    emit.value  = res_value;
    emit.last   = 1'b1;
    emit_pos    = res_pos;
    case (state)
      S_RESP: begin
        emit.vld = out_free;
      end
      S_DUMP: begin
        emit.vld    = out_free;
        emit.status = olws_pkg::ST_OK;
        emit.value  = mem_rdata;
        emit.last   = last_el;
        emit_pos    = idx_p1;
      end
      default: begin
        emit.vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_q  <= req_item;
            idx     <= '0;
            ptr     <= front;
            res_pos <= '0;
            case (req_op)
              olws_pkg::OP_PUSH_FRONT, olws_pkg::OP_PUSH_BACK: begin
                res_value <= req_item;
                state     <= S_RESP;
                if (full) begin
                  res_status <= olws_pkg::ST_FULL;
                end else begin
                  res_status <= olws_pkg::ST_OK;
                  count      <= count + CW'(1);
                  if (req_op == olws_pkg::OP_PUSH_FRONT) begin
                    front <= front_dec;
                  end
                end
              end
              olws_pkg::OP_POP_FRONT, olws_pkg::OP_POP_BACK: begin
                if (empty) begin
                  res_status <= olws_pkg::ST_EMPTY;
                  res_value  <= '0;
                  state      <= S_RESP;
                end else begin
                  count <= cnt_m1;
                  if (req_op == olws_pkg::OP_POP_FRONT) begin
                    front <= front_inc;
                  end
                  state <= S_RDWAIT;
                end
              end
              olws_pkg::OP_SEARCH: begin
                if (empty) begin
                  res_status <= olws_pkg::ST_EMPTY;
                  res_value  <= req_item;
                  state      <= S_RESP;
                end else begin
                  state <= S_SCAN;
                end
              end
              olws_pkg::OP_DUMP: begin
                if (empty) begin
                  res_status <= olws_pkg::ST_EMPTY;
                  res_value  <= '0;
                  state      <= S_RESP;
                end else begin
                  state <= S_DUMP;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          res_status <= olws_pkg::ST_OK;
          res_value  <= mem_rdata;
          state      <= S_RESP;
        end
        S_SCAN: begin
          if (hit) begin
            res_status <= olws_pkg::ST_OK;
            res_value  <= item_q;
            res_pos    <= idx_p1;
            state      <= S_RESP;
          end else if (last_el) begin
            res_status <= olws_pkg::ST_NOTFOUND;
            res_value  <= item_q;
            state      <= S_RESP;
          end else begin
            idx <= idx + IW'(1);
            ptr <= ptr_inc;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            if (last_el) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + IW'(1);
              ptr <= ptr_inc;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/ordered_list_with_search.sv
// ----------------------------------------------------------------------------
// ordered_list_with_search
// Bounded double-ended list in a ring store with linear search and read-out.
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                           transfer when
//  -------  ---  -------------------------------  -------------------------
//  req      in   op, item                         req.valid && req.ready
//  rsp      out  status, value, position, last    rsp.valid && rsp.ready
//
//  Inserts write the store when taken; removes wait on the registered store
//  read. Search steps from the front to the first match or the last element;
//  read-out gives one result per cycle while the rsp register is free. Both
//  are paced by the single read port of the ring store, with one comparator.
//  Reset clears the front index and element count; store contents stay
//  undefined and are never read before being written.
//  Stalls: rsp is an output register; the sequencer waits on it only when it
//  has a new result, so a request can be taken while a result is pending.
//
module ordered_list_with_search #(
  parameter int DEPTH = olws_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  olws_in_if.sink   req,
  olws_out_if.source rsp
);

  localparam int IW    = $clog2(DEPTH);
  localparam int POS_W = $clog2(DEPTH + 1);

  olws_pkg::olws_emit_t               emit;
  logic [POS_W-1:0]                   emit_pos;
  logic                               out_free;

  logic                               mem_we, mem_re;
  logic [IW-1:0]                      mem_waddr, mem_raddr;
  logic signed [olws_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

  // output register
  logic                               rsp_valid;
  logic [olws_pkg::ST_W-1:0]          rsp_status;
  logic signed [olws_pkg::DATA_W-1:0] rsp_value;
  logic [POS_W-1:0]                   rsp_position;
  logic                               rsp_last;

  // slot is free when empty or draining this cycle
  assign out_free = !rsp_valid || rsp.ready;

  olws_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_op    (req.op),
    .req_item  (req.item),
    .out_free  (out_free),
    .emit      (emit),
    .emit_pos  (emit_pos),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  olws_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit.vld) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // payload loads only on a new result; no reset needed
  always_ff @(posedge clk) begin
    if (emit.vld) begin
      rsp_status   <= emit.status;
      rsp_value    <= emit.value;
      rsp_position <= emit_pos;
      rsp_last     <= emit.last;
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.status   = rsp_status;
  assign rsp.value    = rsp_value;
  assign rsp.position = rsp_position;
  assign rsp.last     = rsp_last;

endmodule

### src/olws_checker.sv
// ----------------------------------------------------------------------------
// olws_checker
// Port-level checks for ordered_list_with_search, attached by bind.
// ----------------------------------------------------------------------------
`include "ordered_list_with_search_assert.svh"

module olws_checker #(
  parameter int POS_W = $clog2(olws_pkg::DEPTH_DEF + 1)
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic [olws_pkg::OP_W-1:0]          req_op,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [olws_pkg::ST_W-1:0]          rsp_status,
  input logic signed [olws_pkg::DATA_W-1:0] rsp_value,
  input logic [POS_W-1:0]                   rsp_position,
  input logic                               rsp_last
);

  // out of reset: nothing pending, request side open
  `OLWS_ASSERT_RST(a_reset_clean, !rsp_valid && req_ready, "not idle after reset")

  // one request at a time: a taken request of a known op closes the input in the cycle after
  `OLWS_ASSERT_NEXT(a_one_at_a_time,
    req_valid && req_ready && req_op <= olws_pkg::OP_DUMP,
    !req_ready, "request taken while busy")

  // stalled result holds
  `OLWS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_value) && $stable(rsp_position) &&
    $stable(rsp_status) && $stable(rsp_last), "stalled result changed")

  // error results are single, with no position
  `OLWS_ASSERT_NOW(a_err_single, rsp_valid && rsp_status != olws_pkg::ST_OK,
    rsp_last && rsp_position == '0, "error result malformed")

endmodule

bind ordered_list_with_search olws_checker #(
  .POS_W (POS_W)
) u_olws_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_op       (req.op),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_value    (rsp.value),
  .rsp_position (rsp.position),
  .rsp_last     (rsp.last)
);
